/* hw/rtl/fhp_pkg.sv */
// Shared types, constants and a helper function for the fixed record hex parser.
`timescale 1ns / 1ps
`default_nettype none

package fhp_pkg;

    localparam int VER_DIGITS  = 4;
    localparam int TEMP_DIGITS = 8;
    localparam int POS_W       = 7;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] PRINT_MIN = 8'd32;
    localparam logic [7:0] PRINT_MAX = 8'd126;

    localparam logic signed [31:0] TEMP_LOW_RESET  = -32'sd1000;
    localparam logic signed [31:0] TEMP_HIGH_RESET = 32'sd1000;

    // Register indexes on the configuration port.
    localparam logic REG_TEMP_LOW  = 1'b0;
    localparam logic REG_TEMP_HIGH = 1'b1;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_CHECK,
        ST_FETCH,
        ST_CHAR,
        ST_SUM
    } fhp_state_t;

    typedef struct packed {
        logic take;
        logic latch;
        logic rd_load;
        logic clear;
        logic sel_char;
        logic sel_sum;
    } fhp_cmd_t;

    typedef struct packed {
        logic parse_ok;
        logic id_empty;
        logic chars_left;
    } fhp_status_t;

    // Returns {is_digit, value} for a strict hexadecimal digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            res = {1'b1, 4'(c - 8'h30)};
        end
        else if (c inside {[8'h61:8'h66]}) begin
            res = {1'b1, 4'(c - 8'h57)};
        end
        else if (c inside {[8'h41:8'h46]}) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/fhp_ctrl.sv */
// Controller state machine: sequences byte intake, evaluation and result emission.
`timescale 1ns / 1ps
`default_nettype none

module fhp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              end_of_buffer,
    input  wire logic              out_stall,
    input  wire fhp_pkg::fhp_status_t status,
    output fhp_pkg::fhp_cmd_t      cmd,
    output logic                   in_stall,
    output logic                   out_valid
);
    import fhp_pkg::*;

    fhp_state_t state_reg;
    fhp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (in_valid && end_of_buffer)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.parse_ok && !status.id_empty)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_CHAR;
            end
            ST_CHAR:
            begin
                if (!out_stall)
                begin
                    state_next = status.chars_left ? ST_FETCH : ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (!out_stall)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            ST_CHECK:
            begin
                cmd.latch = 1'b1;
            end
            ST_FETCH:
            begin
                cmd.rd_load = 1'b1;
            end
            ST_CHAR:
            begin
                out_valid    = 1'b1;
                cmd.sel_char = 1'b1;
            end
            ST_SUM:
            begin
                out_valid   = 1'b1;
                cmd.sel_sum = 1'b1;
                cmd.clear   = !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/fhp_datapath.sv */
// Datapath: field accumulators, id character memory and summary registers.
`timescale 1ns / 1ps
`default_nettype none

module fhp_datapath #(
    parameter int ID_FIELD_BYTES = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fhp_pkg::fhp_cmd_t   cmd,
    input  wire logic [7:0]          data_byte,
    input  wire logic signed [31:0]  temp_low,
    input  wire logic signed [31:0]  temp_high,
    output fhp_pkg::fhp_status_t     status,
    output logic [7:0]               id_char,
    output logic                     char_valid,
    output logic                     last,
    output logic                     parse_ok,
    output logic [15:0]              version,
    output logic signed [31:0]       temperature,
    output logic                     active,
    output logic [5:0]               id_length,
    output logic                     validate_ok,
    output logic [31:0]              checksum
);
    import fhp_pkg::*;

    localparam int ID_DEPTH = ID_FIELD_BYTES - 1;
    localparam int IDX_W    = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;

    localparam logic [POS_W-1:0] ID_START   = POS_W'(VER_DIGITS);
    localparam logic [POS_W-1:0] TEMP_START = POS_W'(VER_DIGITS + ID_FIELD_BYTES);
    localparam logic [POS_W-1:0] FLAG_POS   =
        POS_W'(VER_DIGITS + ID_FIELD_BYTES + TEMP_DIGITS);
    localparam logic [POS_W-1:0] RECORD_LEN =
        POS_W'(VER_DIGITS + ID_FIELD_BYTES + TEMP_DIGITS + 1);
    localparam logic [5:0] ID_MAX = 6'(ID_DEPTH);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      ver_reg, ver_next;
    logic [31:0]      temp_reg, temp_next;
    logic [5:0]       id_count_reg, id_count_next;
    logic             id_closed_reg, id_closed_next;
    logic             id_printable_reg, id_printable_next;
    logic [31:0]      id_sum_reg, id_sum_next;
    logic             fmt_err_reg, fmt_err_next;
    logic             active_reg, active_next;
    logic [5:0]       rd_idx_reg;
    logic [7:0]       rd_data_reg;

    logic             ok_reg;
    logic             validate_reg;
    logic [31:0]      checksum_reg;

    logic [7:0]       id_mem [ID_DEPTH];
    logic             mem_we;
    logic [4:0]       hex;
    logic             record_ok;
    logic             in_range;

    assign hex = hex_decode(data_byte);

    always_comb
    begin
        pos_next          = pos_reg;
        ver_next          = ver_reg;
        temp_next         = temp_reg;
        id_count_next     = id_count_reg;
        id_closed_next    = id_closed_reg;
        id_printable_next = id_printable_reg;
        id_sum_next       = id_sum_reg;
        fmt_err_next      = fmt_err_reg;
        active_next       = active_reg;
        mem_we            = 1'b0;
        if (cmd.take && (pos_reg < RECORD_LEN))
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg < ID_START)
            begin
                if (!hex[4])
                begin
                    fmt_err_next = 1'b1;
                end
                else
                begin
                    ver_next = {ver_reg[11:0], hex[3:0]};
                end
            end
            else if (pos_reg < TEMP_START)
            begin
                if (!id_closed_reg)
                begin
                    if ((data_byte == CH_NUL) || (data_byte == CH_PIPE))
                    begin
                        id_closed_next = 1'b1;
                    end
                    else if (id_count_reg < ID_MAX)
                    begin
                        mem_we        = 1'b1;
                        id_count_next = id_count_reg + 6'd1;
                        id_sum_next   = id_sum_reg + 32'(data_byte);
                        if ((data_byte < PRINT_MIN) || (data_byte > PRINT_MAX))
                        begin
                            id_printable_next = 1'b0;
                        end
                        if (id_count_reg == (ID_MAX - 6'd1))
                        begin
                            id_closed_next = 1'b1;
                        end
                    end
                end
            end
            else if (pos_reg < FLAG_POS)
            begin
                if (!hex[4])
                begin
                    fmt_err_next = 1'b1;
                end
                else
                begin
                    temp_next = {temp_reg[27:0], hex[3:0]};
                end
            end
            else
            begin
                if (data_byte == CH_ONE)
                begin
                    active_next = 1'b1;
                end
                else if (data_byte == CH_ZERO)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    fmt_err_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            ver_reg          <= '0;
            temp_reg         <= '0;
            id_count_reg     <= '0;
            id_closed_reg    <= 1'b0;
            id_printable_reg <= 1'b1;
            id_sum_reg       <= '0;
            fmt_err_reg      <= 1'b0;
            active_reg       <= 1'b0;
            rd_idx_reg       <= '0;
        end
        else if (cmd.clear)
        begin
            pos_reg          <= '0;
            ver_reg          <= '0;
            temp_reg         <= '0;
            id_count_reg     <= '0;
            id_closed_reg    <= 1'b0;
            id_printable_reg <= 1'b1;
            id_sum_reg       <= '0;
            fmt_err_reg      <= 1'b0;
            active_reg       <= 1'b0;
            rd_idx_reg       <= '0;
        end
        else
        begin
            pos_reg          <= pos_next;
            ver_reg          <= ver_next;
            temp_reg         <= temp_next;
            id_count_reg     <= id_count_next;
            id_closed_reg    <= id_closed_next;
            id_printable_reg <= id_printable_next;
            id_sum_reg       <= id_sum_next;
            fmt_err_reg      <= fmt_err_next;
            active_reg       <= active_next;
            if (cmd.rd_load)
            begin
                rd_idx_reg <= rd_idx_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[id_count_reg[IDX_W-1:0]] <= data_byte;
        end
        if (cmd.rd_load)
        begin
            rd_data_reg <= id_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // The position counter saturates at the record length, so equality means complete.
    assign record_ok = (pos_reg == RECORD_LEN) && !fmt_err_reg;
    assign in_range  = ($signed(temp_reg) >= temp_low) && ($signed(temp_reg) <= temp_high);

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            ok_reg       <= record_ok;
            validate_reg <= (id_count_reg != 6'd0) && id_printable_reg && in_range;
            checksum_reg <= 32'(ver_reg) + temp_reg + 32'(active_reg) + id_sum_reg;
        end
    end

    assign status.parse_ok   = record_ok;
    assign status.id_empty   = (id_count_reg == 6'd0);
    assign status.chars_left = (rd_idx_reg != id_count_reg);

    logic show_sum;
    assign show_sum = cmd.sel_sum && ok_reg;

    assign id_char     = cmd.sel_char ? rd_data_reg : 8'd0;
    assign char_valid  = cmd.sel_char;
    assign last        = cmd.sel_sum;
    assign parse_ok    = show_sum;
    assign version     = show_sum ? ver_reg : 16'd0;
    assign temperature = show_sum ? $signed(temp_reg) : 32'sd0;
    assign active      = show_sum && active_reg;
    assign id_length   = show_sum ? id_count_reg : 6'd0;
    assign validate_ok = show_sum && validate_reg;
    assign checksum    = show_sum ? checksum_reg : 32'd0;

endmodule

`default_nettype wire

/* hw/rtl/fixed_record_hex_parser_unit.sv */
// Flow: bytes are taken one per cycle while in_stall is low. After the last byte comes an
// evaluation step; for a parsed record with a non-empty id, a memory read and a present step
// per id character follow, then one summary item. Output steps hold while out_stall is high.
// No new buffer is taken until the summary of the last one has been delivered.
// Reset: asynchronous, active low; clears the controller and accumulators and sets the
// temperature limits to -1000 and 1000. The id memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module fixed_record_hex_parser_unit #(
    parameter int ID_FIELD_BYTES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               end_of_buffer,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              id_char,
    output logic                    char_valid,
    output logic                    last,
    output logic                    parse_ok,
    output logic [15:0]             version,
    output logic signed [31:0]      temperature,
    output logic                    active,
    output logic [5:0]              id_length,
    output logic                    validate_ok,
    output logic [31:0]             checksum
);
    import fhp_pkg::*;

    logic signed [31:0] temp_low_reg;
    logic signed [31:0] temp_high_reg;
    logic               cfg_write;
    fhp_cmd_t           cmd;
    fhp_status_t        status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_low_reg  <= TEMP_LOW_RESET;
            temp_high_reg <= TEMP_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_TEMP_LOW)
            begin
                temp_low_reg <= $signed(pwdata);
            end
            else
            begin
                temp_high_reg <= $signed(pwdata);
            end
        end
    end

    assign prdata = (paddr[2] == REG_TEMP_HIGH) ? temp_high_reg : temp_low_reg;

    fhp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .end_of_buffer (end_of_buffer),
        .out_stall     (out_stall),
        .status        (status),
        .cmd           (cmd),
        .in_stall      (in_stall),
        .out_valid     (out_valid)
    );

    fhp_datapath #(
        .ID_FIELD_BYTES (ID_FIELD_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .temp_low    (temp_low_reg),
        .temp_high   (temp_high_reg),
        .status      (status),
        .id_char     (id_char),
        .char_valid  (char_valid),
        .last        (last),
        .parse_ok    (parse_ok),
        .version     (version),
        .temperature (temperature),
        .active      (active),
        .id_length   (id_length),
        .validate_ok (validate_ok),
        .checksum    (checksum)
    );

endmodule

`default_nettype wire

/* hw/rtl/fhp_checker.sv */
// Port-level checker for the parser, attached to the top level by a bind statement.
`timescale 1ns / 1ps
`default_nettype none

module fhp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        end_of_buffer,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  id_char,
    input wire logic        char_valid,
    input wire logic        last,
    input wire logic        parse_ok,
    input wire logic [15:0] version,
    input wire logic [31:0] temperature,
    input wire logic        active,
    input wire logic [5:0]  id_length,
    input wire logic        validate_ok,
    input wire logic [31:0] checksum
);

    // The end of a buffer closes the input until its results are delivered.
    a_end_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && end_of_buffer |=> in_stall)
        else $error("input still open after end of buffer");

    a_no_intake_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a result is pending");

    // A failed parse reports nothing but the end marker.
    a_failed_summary_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !parse_ok |-> (version == 16'd0) && (temperature == 32'd0)
            && (checksum == 32'd0) && (id_length == 6'd0) && !validate_ok && !active)
        else $error("failed summary carries field data");

    a_char_not_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_valid |-> !last && !parse_ok && (checksum == 32'd0))
        else $error("character transaction carries summary data");

    a_stalled_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(id_char) && $stable(last))
        else $error("stalled output transaction changed");

endmodule

bind fixed_record_hex_parser_unit fhp_checker u_fhp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .end_of_buffer (end_of_buffer),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .id_char       (id_char),
    .char_valid    (char_valid),
    .last          (last),
    .parse_ok      (parse_ok),
    .version       (version),
    .temperature   (temperature),
    .active        (active),
    .id_length     (id_length),
    .validate_ok   (validate_ok),
    .checksum      (checksum)
);

`default_nettype wire

/* test/tb_fixed_record_hex_parser_unit.sv */
// Self-checking testbench for the fixed record hex parser: records in, id characters and summaries out.
`timescale 1ns / 1ps

module tb_fixed_record_hex_parser_unit;
    import fhp_pkg::*;

    localparam int ID_BYTES    = 64;
    localparam int ID_MAX      = ID_BYTES - 1;
    localparam int TEMP_START  = VER_DIGITS + ID_BYTES;
    localparam int FLAG_POS    = TEMP_START + TEMP_DIGITS;
    localparam int RECORD_LEN  = FLAG_POS + 1;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    // Bytes just outside the hex digit ranges, plus whitespace, signs and the 'x' of a prefix.
    localparam logic [87:0] NEAR_HEX = {8'h20, 8'h2B, 8'h2D, 8'h2F, 8'h3A, 8'h40,
                                        8'h47, 8'h60, 8'h67, 8'h78, 8'h58};

    typedef struct packed {
        logic [7:0]  id_char;
        logic        char_valid;
        logic        last;
        logic        parse_ok;
        logic [15:0] version;
        logic [31:0] temperature;
        logic        active;
        logic [5:0]  id_length;
        logic        validate_ok;
        logic [31:0] checksum;
    } parser_result_t;

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    class record_scoreboard;
        parser_result_t     record_items_q[$];
        logic signed [31:0] temp_low;
        logic signed [31:0] temp_high;
        int                 failures;
        int                 position;
        logic [15:0]        ver_acc;
        logic [31:0]        temp_acc;
        logic [7:0]         id_chars[$];
        logic [31:0]        id_sum;
        bit                 id_closed;
        bit                 id_printable;
        bit                 fmt_err;
        bit                 active_flag;

        function new();
            temp_low = TEMP_LOW_RESET;
            temp_high = TEMP_HIGH_RESET;
            failures = 0;
            clear_record();
        endfunction

        function void clear_record();
            position = 0;
            ver_acc = '0;
            temp_acc = '0;
            id_chars.delete();
            id_sum = '0;
            id_closed = 0;
            id_printable = 1;
            fmt_err = 0;
            active_flag = 0;
        endfunction

        function void set_limit(input logic idx, input logic [31:0] value);
            if (idx == REG_TEMP_LOW) temp_low = value;
            else temp_high = value;
        endfunction

        function int pending();
            return record_items_q.size();
        endfunction

        // Advances the parse by one accepted byte; at the buffer end, queues the items it emits.
        function void parse_byte(input logic [7:0] b, input logic eob);
            parser_result_t r;
            int hv;
            bit ok;
            bit in_range;
            if (position < RECORD_LEN) begin
                if (position < VER_DIGITS) begin
                    hv = hex_digit_value(b);
                    if (hv < 0) fmt_err = 1;
                    else ver_acc = {ver_acc[11:0], 4'(hv)};
                end
                else if (position < TEMP_START) begin
                    if (!id_closed) begin
                        if (b == CH_NUL || b == CH_PIPE) begin
                            id_closed = 1;
                        end
                        else if (id_chars.size() < ID_MAX) begin
                            id_chars.push_back(b);
                            id_sum += {24'h0, b};
                            if (b < PRINT_MIN || b > PRINT_MAX) id_printable = 0;
                            if (id_chars.size() >= ID_MAX) id_closed = 1;
                        end
                    end
                end
                else if (position < FLAG_POS) begin
                    hv = hex_digit_value(b);
                    if (hv < 0) fmt_err = 1;
                    else temp_acc = {temp_acc[27:0], 4'(hv)};
                end
                else begin
                    if (b == CH_ONE) active_flag = 1;
                    else if (b == CH_ZERO) active_flag = 0;
                    else fmt_err = 1;
                end
                position++;
            end
            if (!eob) return;

            ok = (position >= RECORD_LEN) && !fmt_err;
            if (ok) begin
                foreach (id_chars[i]) begin
                    r = '0;
                    r.id_char = id_chars[i];
                    r.char_valid = 1'b1;
                    record_items_q.push_back(r);
                end
            end
            r = '0;
            r.last = 1'b1;
            if (ok) begin
                in_range = ($signed(temp_acc) >= temp_low) && ($signed(temp_acc) <= temp_high);
                r.parse_ok = 1'b1;
                r.version = ver_acc;
                r.temperature = temp_acc;
                r.active = active_flag;
                r.id_length = 6'(id_chars.size());
                r.validate_ok = (id_chars.size() != 0) && id_printable && in_range;
                r.checksum = {16'h0, ver_acc} + temp_acc + {31'h0, active_flag} + id_sum;
            end
            record_items_q.push_back(r);
            clear_record();
        endfunction

        function void check_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                failures++;
            end
        endfunction

        function void compare_item(input parser_result_t got);
            parser_result_t want;
            if (record_items_q.size() == 0) begin
                $error("result transaction with nothing outstanding: id_char %0h last %0b",
                       got.id_char, got.last);
                failures++;
                return;
            end
            want = record_items_q.pop_front();
            check_field("id_char", want.id_char, got.id_char);
            check_field("char_valid", want.char_valid, got.char_valid);
            check_field("last", want.last, got.last);
            check_field("parse_ok", want.parse_ok, got.parse_ok);
            check_field("version", want.version, got.version);
            check_field("temperature", want.temperature, got.temperature);
            check_field("active", want.active, got.active);
            check_field("id_length", want.id_length, got.id_length);
            check_field("validate_ok", want.validate_ok, got.validate_ok);
            check_field("checksum", want.checksum, got.checksum);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = '0;
    logic               end_of_buffer = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         id_char;
    logic               char_valid;
    logic               last;
    logic               parse_ok;
    logic [15:0]        version;
    logic signed [31:0] temperature;
    logic               active;
    logic [5:0]         id_length;
    logic               validate_ok;
    logic [31:0]        checksum;

    record_scoreboard sb;
    logic [7:0]       record_bytes[$];
    parser_result_t   rx_item;
    int               bytes_sent = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               hold_asked = 0;
    int               hold_taken = 0;
    int               hold_left = 0;
    int               quiet_cycles = 0;

    fixed_record_hex_parser_unit #(
        .ID_FIELD_BYTES(ID_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .end_of_buffer(end_of_buffer),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .id_char(id_char),
        .char_valid(char_valid),
        .last(last),
        .parse_ok(parse_ok),
        .version(version),
        .temperature(temperature),
        .active(active),
        .id_length(id_length),
        .validate_ok(validate_ok),
        .checksum(checksum)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            rx_item.id_char = id_char;
            rx_item.char_valid = char_valid;
            rx_item.last = last;
            rx_item.parse_ok = parse_ok;
            rx_item.version = version;
            rx_item.temperature = temperature;
            rx_item.active = active;
            rx_item.id_length = id_length;
            rx_item.validate_ok = validate_ok;
            rx_item.checksum = checksum;
            sb.compare_item(rx_item);
        end
        if (hold_taken != hold_asked) begin
            hold_left = HOLD_CYCLES;
            hold_taken = hold_asked;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_fixed_record_hex_parser_unit: FAIL");
            $finish;
        end
    end

    task automatic write_limit(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_limit(idx, value);
        @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_buffer <= eob;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        sb.parse_byte(b, eob);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < record_bytes.size(); i++) begin
            send_byte(record_bytes[i], i == record_bytes.size() - 1);
        end
    endtask

    // Every buffer ends with its last byte marked, so once all items are in, the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) record_bytes.push_back(s[i]);
    endtask

    task automatic add_filler(input int n);
        repeat (n) record_bytes.push_back(8'($urandom));
    endtask

    task automatic add_hex(input logic [31:0] value, input int digits);
        logic [3:0] nib;
        for (int i = digits - 1; i >= 0; i--) begin
            nib = value[4*i +: 4];
            if (nib < 10) record_bytes.push_back(8'h30 + nib);
            else record_bytes.push_back(($urandom_range(1) ? 8'h61 : 8'h41) + nib - 8'd10);
        end
    endtask

    task automatic build_record(input logic [15:0] ver, input int id_len, input bit printable,
                                input logic [31:0] temp, input logic [7:0] flag);
        logic [7:0] c;
        record_bytes.delete();
        add_hex(ver, VER_DIGITS);
        for (int i = 0; i < id_len && i < ID_BYTES; i++) begin
            do begin
                if (printable) c = 8'($urandom_range(PRINT_MAX, PRINT_MIN));
                else c = 8'($urandom_range(255, 1));
            end while (c == CH_PIPE);
            record_bytes.push_back(c);
        end
        if (id_len < ID_BYTES) begin
            record_bytes.push_back($urandom_range(1) ? CH_NUL : CH_PIPE);
            add_filler(ID_BYTES - id_len - 1);
        end
        add_hex(temp, TEMP_DIGITS);
        record_bytes.push_back(flag);
    endtask

    // Temperatures cluster on both limits so that validation goes both ways at each edge.
    function automatic logic [31:0] pick_temp();
        case ($urandom_range(3))
            0: return $urandom;
            1: return sb.temp_low + $urandom_range(4) - 2;
            2: return sb.temp_high + $urandom_range(4) - 2;
            default: return $urandom_range(4000) - 2000;
        endcase
    endfunction

    task automatic run_phase(input int sender_pct, input int receiver_pct,
                             input logic [31:0] lo, input logic [31:0] hi,
                             input int target, input bit with_hold);
        int start;
        int kind;
        int id_len;
        int pick;
        int idx;
        int cut;
        logic [7:0] c;
        start = bytes_sent;
        write_limit(REG_TEMP_LOW, lo);
        write_limit(REG_TEMP_HIGH, hi);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        if (with_hold) begin
            // The receiver stops for a long stretch while a full record goes in behind it.
            build_record(16'($urandom), 20, 1, pick_temp(), CH_ONE);
            hold_asked++;
            send_buffer();
        end
        while (bytes_sent - start < target) begin
            kind = $urandom_range(99);
            pick = $urandom_range(9);
            if (pick == 0) id_len = 0;
            else if (pick == 1) id_len = $urandom_range(ID_BYTES, ID_MAX);
            else id_len = $urandom_range(20, 1);
            build_record(16'($urandom), id_len, $urandom_range(4) != 0, pick_temp(),
                         $urandom_range(1) ? CH_ONE : CH_ZERO);
            if (kind < 55) begin
                if ($urandom_range(4) == 0) add_filler($urandom_range(5, 1));
            end
            else if (kind < 75) begin
                pick = $urandom_range(2);
                if (pick == 2) begin
                    do c = 8'($urandom); while (c == CH_ONE || c == CH_ZERO);
                    record_bytes[FLAG_POS] = c;
                end
                else begin
                    if ($urandom_range(1)) begin
                        idx = $urandom_range(10);
                        c = NEAR_HEX[8*idx +: 8];
                    end
                    else begin
                        do c = 8'($urandom); while (hex_digit_value(c) >= 0);
                    end
                    if (pick == 0) idx = $urandom_range(VER_DIGITS - 1);
                    else idx = TEMP_START + $urandom_range(TEMP_DIGITS - 1);
                    record_bytes[idx] = c;
                end
            end
            else begin
                cut = $urandom_range(RECORD_LEN - 1, 1);
                while (record_bytes.size() > cut) void'(record_bytes.pop_back());
            end
            send_buffer();
        end
        drain();
    endtask

    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 20;
        recv_idle_pct = 20;

        // A lone byte is a short buffer.
        record_bytes.delete();
        record_bytes.push_back(8'hFF);
        send_buffer();

        // Mixed-case digits, a NUL-terminated id and a temperature on the lower limit.
        record_bytes.delete();
        add_text("FfA0");
        add_text("Ab");
        record_bytes.push_back(CH_NUL);
        add_filler(ID_BYTES - 3);
        add_text("FFFFFC18");
        record_bytes.push_back(CH_ONE);
        send_buffer();

        // Empty id closed by a pipe, temperature on the upper limit.
        record_bytes.delete();
        add_text("0000");
        record_bytes.push_back(CH_PIPE);
        add_filler(ID_BYTES - 1);
        add_text("000003e8");
        record_bytes.push_back(CH_ZERO);
        send_buffer();

        // Id area with no terminator and unprintable bytes, most negative temperature,
        // followed by bytes past the end of the record.
        record_bytes.delete();
        add_text("9a7F");
        record_bytes.push_back(8'h80);
        record_bytes.push_back(8'hFF);
        record_bytes.push_back(8'h7E);
        record_bytes.push_back(8'h20);
        record_bytes.push_back(8'h1F);
        record_bytes.push_back(8'h01);
        repeat (ID_BYTES - 6) record_bytes.push_back(8'h7A);
        add_text("80000000");
        record_bytes.push_back(CH_ONE);
        record_bytes.push_back(CH_NUL);
        record_bytes.push_back(CH_PIPE);
        record_bytes.push_back(8'h58);
        send_buffer();

        // Empty id at a NUL and the largest temperature.
        record_bytes.delete();
        add_text("ffff");
        record_bytes.push_back(CH_NUL);
        add_filler(ID_BYTES - 1);
        add_text("7FFFFFFF");
        record_bytes.push_back(CH_ZERO);
        send_buffer();

        // Leading whitespace in the version.
        build_record(16'h0123, 3, 1, 32'h10, CH_ONE);
        record_bytes[0] = 8'h20;
        send_buffer();

        // A 0x prefix inside the temperature.
        build_record(16'h4567, 2, 1, 32'h10, CH_ONE);
        record_bytes[TEMP_START + 1] = 8'h78;
        send_buffer();

        // A flag byte that is neither one nor zero.
        build_record(16'h89AB, 4, 1, 32'h5, 8'h32);
        send_buffer();

        // A record one byte short.
        build_record(16'hCDEF, 5, 1, 32'h5, CH_ONE);
        void'(record_bytes.pop_back());
        send_buffer();
        drain();

        run_phase(27, 83, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
        run_phase(83, 27, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0);
        lo = 32'd0 - 32'($urandom_range(5000));
        hi = 32'($urandom_range(5000));
        run_phase(0, 0, lo, hi, 1, 1);

        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("tb_fixed_record_hex_parser_unit: PASS");
        end
        else begin
            $display("tb_fixed_record_hex_parser_unit: FAIL");
        end
        $finish;
    end

endmodule
